/* hw/rtl/pte_pkg.sv */
`default_nettype none
package pte_pkg;

    localparam int PTE_MAX_VARS    = 64;
    localparam int PTE_MAX_ENTRIES = 1024;
    localparam int PTE_LEVEL_BITS  = 32;

    localparam int OP_W      = 3;
    localparam int VAR_W     = 6;
    localparam int VALUE_W   = 10;
    localparam int AMOUNT_W  = 32;
    localparam int DSZ_W     = 11;
    localparam int OUT_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int DECAY_W   = 17;

    typedef enum logic [OP_W-1:0] {
        OP_DEFINE    = 3'd0,
        OP_FILL      = 3'd1,
        OP_READ      = 3'd2,
        OP_ADD       = 3'd3,
        OP_EVAPORATE = 3'd4,
        OP_EXTREMES  = 3'd5
    } t_op;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd2;

    localparam logic [CFG_W-1:0]   MIN_LEVEL_RST = 32'd655;
    localparam logic [CFG_W-1:0]   MAX_LEVEL_RST = 32'd6553600;
    localparam logic [DECAY_W-1:0] DECAY_RST     = 17'd62259;
    localparam logic [DECAY_W-1:0] DECAY_ONE     = 17'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEFINE,
        S_CALC,
        S_LVL_RD,
        S_RMW,
        S_SWEEP,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic sweep_init;
        logic sweep_step;
        logic calc;
        logic define;
        logic rmw;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_done;
        logic            pipe_empty;
    } t_stat;

endpackage
`default_nettype wire

/* hw/rtl/pheromone_table_engine_unit.sv */
`default_nettype none
// From the start transfer to o_done, unused codes finish straight after decode;
// define adds the define step; read and add pass through start offset lookup,
// address, level read and write-back. Fill, evaporate and extremes walk the used
// entries one per cycle; evaporate and extremes then drain their read pipeline.
// Reset clears the layout (no variables, no used entries) and loads the register
// defaults; the level table itself holds no reset value. The receiver cannot stall.
module pheromone_table_engine_unit
    import pte_pkg::*;
#(
    parameter int MAX_VARS    = PTE_MAX_VARS,
    parameter int MAX_ENTRIES = PTE_MAX_ENTRIES,
    parameter int LEVEL_BITS  = PTE_LEVEL_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [VAR_W-1:0]     i_var_req,
    input  wire logic [VALUE_W-1:0]   i_value,
    input  wire logic [AMOUNT_W-1:0]  i_amount,
    input  wire logic [DSZ_W-1:0]     i_domain_size,
    output logic                      o_done,
    output logic [OUT_W-1:0]          o_level,
    output logic [OUT_W-1:0]          o_lowest_level,
    output logic [OUT_W-1:0]          o_highest_level,
    output logic [STATUS_W-1:0]       o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pte_datapath #(
        .MAX_VARS    (MAX_VARS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_var_req       (i_var_req),
        .i_value         (i_value),
        .i_amount        (i_amount),
        .i_domain_size   (i_domain_size),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_level         (o_level),
        .o_lowest_level  (o_lowest_level),
        .o_highest_level (o_highest_level),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

/* hw/rtl/pte_ctrl.sv */
`default_nettype none
module pte_ctrl
    import pte_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_DEFINE: begin
                        n_state = S_DEFINE;
                    end
                    OP_READ, OP_ADD: begin
                        n_state = S_CALC;
                    end
                    OP_FILL, OP_EVAPORATE, OP_EXTREMES: begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_SWEEP;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_DEFINE: begin
                o_cmd.define = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_LVL_RD;
            end
            S_LVL_RD: begin
                n_state = S_RMW;
            end
            S_RMW: begin
                o_cmd.rmw    = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            S_DRAIN: begin
                // wait for the last write-back or compare to land
                if (i_stat.pipe_empty) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after result");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> (r_state == S_IDLE))
        else $error("controller left idle without a start");

    a_step_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_step |-> (r_state == S_SWEEP && !i_stat.sweep_done))
        else $error("sweep step issued outside an active sweep");

endmodule
`default_nettype wire

/* hw/rtl/pte_datapath.sv */
`default_nettype none
module pte_datapath
    import pte_pkg::*;
#(
    parameter int MAX_VARS    = PTE_MAX_VARS,
    parameter int MAX_ENTRIES = PTE_MAX_ENTRIES,
    parameter int LEVEL_BITS  = PTE_LEVEL_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [VAR_W-1:0]     i_var_req,
    input  wire logic [VALUE_W-1:0]   i_value,
    input  wire logic [AMOUNT_W-1:0]  i_amount,
    input  wire logic [DSZ_W-1:0]     i_domain_size,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_done,
    output logic [OUT_W-1:0]          o_level,
    output logic [OUT_W-1:0]          o_lowest_level,
    output logic [OUT_W-1:0]          o_highest_level,
    output logic [STATUS_W-1:0]       o_status
);

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int VW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int DVW = $clog2(MAX_VARS + 1);
    localparam int WW  = (LEVEL_BITS > CFG_W) ? LEVEL_BITS : CFG_W;
    localparam int PW  = ((CW > VALUE_W) ? CW : VALUE_W) + 1;
    localparam int BW  = ((CW > DSZ_W) ? CW : DSZ_W) + 1;
    localparam int MW  = LEVEL_BITS + DECAY_W;
    localparam int LW  = 16 + DECAY_W;

    // captured request
    logic [OP_W-1:0]     r_op;
    logic [VAR_W-1:0]    r_var;
    logic [VALUE_W-1:0]  r_value;
    logic [AMOUNT_W-1:0] r_amount;
    logic [DSZ_W-1:0]    r_dsz;

    // configuration
    logic [CFG_W-1:0]   r_min;
    logic [CFG_W-1:0]   r_max;
    logic [DECAY_W-1:0] r_decay;

    // stores
    logic [LEVEL_BITS-1:0] level_mem [MAX_ENTRIES];
    logic [CW-1:0]         start_mem [MAX_VARS];

    logic [CW-1:0]         r_start_q;
    logic [CW-1:0]         r_used;
    logic [DVW-1:0]        r_defined;
    logic [CW-1:0]         r_idx;
    logic [AW-1:0]         r_pos;
    logic                  r_hit;
    logic [LEVEL_BITS-1:0] r_rd_q;
    logic                  r_vld1;
    logic [AW-1:0]         r_addr1;
    logic [MW-1:0]         r_ph;
    logic [LW-1:0]         r_pl;
    logic                  r_vld2;
    logic [AW-1:0]         r_addr2;
    logic [LEVEL_BITS-1:0] r_lo;
    logic [LEVEL_BITS-1:0] r_hi;

    logic [OUT_W-1:0]    r_level;
    logic [OUT_W-1:0]    r_lowest;
    logic [OUT_W-1:0]    r_highest;
    logic [STATUS_W-1:0] r_status;
    logic                r_done;

    // clamp levels
    logic [WW-1:0]         max_w;
    logic [WW-1:0]         min_w;
    logic [WW-1:0]         mask_w;
    logic [LEVEL_BITS-1:0] top;
    logic [LEVEL_BITS-1:0] bottom;

    assign mask_w = WW'({LEVEL_BITS{1'b1}});
    assign max_w  = WW'(r_max);
    assign min_w  = WW'(r_min);
    assign top    = LEVEL_BITS'((max_w > mask_w) ? mask_w : max_w);
    assign bottom = LEVEL_BITS'((min_w > mask_w) ? mask_w : min_w);

    // define
    logic [CW-1:0]       base;
    logic [BW-1:0]       def_sum;
    logic [STATUS_W-1:0] def_status;

    assign base    = (r_var == '0) ? '0 : r_used;
    assign def_sum = BW'(base) + BW'(r_dsz);

    always_comb begin
        if (32'(r_var) >= 32'(MAX_VARS) || 32'(r_var) > 32'(r_defined)) begin
            def_status = ST_RANGE;
        end else if (def_sum > BW'(MAX_ENTRIES)) begin
            def_status = ST_FULL;
        end else begin
            def_status = ST_OK;
        end
    end

    // entry lookup
    logic [PW-1:0] pos;
    logic          hit;

    assign pos = PW'(r_start_q) + PW'(r_value);
    assign hit = (32'(r_var) < 32'(r_defined)) && (32'(r_var) < 32'(MAX_VARS))
              && (pos < PW'(r_used));

    // deposit
    logic [WW:0]           sum_w;
    logic [LEVEL_BITS-1:0] add_val;

    assign sum_w   = (WW + 1)'(r_rd_q) + (WW + 1)'(r_amount);
    assign add_val = (sum_w > (WW + 1)'(top)) ? top : LEVEL_BITS'(sum_w);

    // evaporation: split at the binary point, multiply both halves
    logic [DECAY_W-1:0]       d_eff;
    logic [LEVEL_BITS+15:0]   ext;
    logic [MW-1:0]            n_ph;
    logic [LW-1:0]            n_pl;
    logic [MW-1:0]            evap_sum;
    logic [LEVEL_BITS-1:0]    evap_val;

    assign d_eff    = (r_decay > DECAY_ONE) ? DECAY_ONE : r_decay;
    assign ext      = {16'b0, r_rd_q};
    assign n_ph     = MW'(ext[LEVEL_BITS+15:16]) * MW'(d_eff);
    assign n_pl     = LW'(ext[15:0]) * LW'(d_eff);
    assign evap_sum = r_ph + MW'(r_pl[LW-1:16]);
    assign evap_val = (evap_sum < MW'(bottom)) ? bottom : LEVEL_BITS'(evap_sum);

    // level store ports
    logic                  fill_we;
    logic                  evap_we;
    logic                  add_we;
    logic [AW-1:0]         wr_addr;
    logic [LEVEL_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;

    assign fill_we = i_cmd.sweep_step && (r_op == OP_FILL);
    assign evap_we = r_vld2;
    assign add_we  = i_cmd.rmw && (r_op == OP_ADD) && r_hit;
    assign rd_addr = i_cmd.sweep_step ? r_idx[AW-1:0] : r_pos;

    always_comb begin
        wr_addr = r_pos;
        wr_data = add_val;
        if (fill_we) begin
            wr_addr = r_idx[AW-1:0];
            wr_data = top;
        end else if (evap_we) begin
            wr_addr = r_addr2;
            wr_data = evap_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we || evap_we || add_we) begin
            level_mem[wr_addr] <= wr_data;
        end
        r_rd_q <= level_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.define && def_status == ST_OK) begin
            start_mem[VW'(r_var)] <= base;
        end
        r_start_q <= start_mem[VW'(r_var)];
    end

    // request capture and payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_var    <= i_var_req;
            r_value  <= i_value;
            r_amount <= i_amount;
            r_dsz    <= i_domain_size;
        end
        if (i_cmd.calc) begin
            r_pos <= AW'(pos);
            r_hit <= hit;
        end
        r_addr1 <= r_idx[AW-1:0];
        r_addr2 <= r_addr1;
        r_ph    <= n_ph;
        r_pl    <= n_pl;
        if (i_cmd.sweep_init) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (r_vld1 && r_op == OP_EXTREMES) begin
            if (r_rd_q < r_lo) begin
                r_lo <= r_rd_q;
            end
            if (r_rd_q > r_hi) begin
                r_hi <= r_rd_q;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= MIN_LEVEL_RST;
            r_max     <= MAX_LEVEL_RST;
            r_decay   <= DECAY_RST;
            r_used    <= '0;
            r_defined <= '0;
            r_idx     <= '0;
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_LEVEL: r_min   <= i_cfg_data;
                    CFG_MAX_LEVEL: r_max   <= i_cfg_data;
                    CFG_DECAY:     r_decay <= DECAY_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.define && def_status == ST_OK) begin
                r_used    <= CW'(def_sum);
                r_defined <= DVW'(32'(r_var) + 32'd1);
            end
            if (i_cmd.sweep_init) begin
                r_idx <= '0;
            end else if (i_cmd.sweep_step) begin
                r_idx <= r_idx + CW'(1);
            end
            r_vld1 <= i_cmd.sweep_step && (r_op == OP_EVAPORATE || r_op == OP_EXTREMES);
            r_vld2 <= r_vld1 && (r_op == OP_EVAPORATE);
            r_done <= i_cmd.finish;
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_level   <= '0;
            r_lowest  <= '0;
            r_highest <= '0;
            r_status  <= ST_OK;
            case (r_op) inside
                OP_DEFINE: begin
                    r_status <= def_status;
                end
                OP_READ, OP_ADD: begin
                    if (r_hit) begin
                        r_level <= (r_op == OP_ADD) ? OUT_W'(add_val) : OUT_W'(r_rd_q);
                    end else begin
                        r_status <= ST_RANGE;
                    end
                end
                OP_EXTREMES: begin
                    if (r_used != '0) begin
                        r_lowest  <= OUT_W'(r_lo);
                        r_highest <= OUT_W'(r_hi);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.sweep_done = (r_idx == r_used);
    assign o_stat.pipe_empty = !r_vld1 && !r_vld2;

    assign o_done          = r_done;
    assign o_level         = r_level;
    assign o_lowest_level  = r_lowest;
    assign o_highest_level = r_highest;
    assign o_status        = r_status;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({fill_we, evap_we, add_we}))
        else $error("level store written from two sources");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(MAX_ENTRIES))
        else $error("used entry count beyond table size");

endmodule
`default_nettype wire
